// ----- hw/rtl/stq_pkg.sv -----
// package for the sorted timer expiry queue: opcodes, status codes, command types
package stq_pkg;
  localparam int DepthDefault = 16;
  localparam int MaxOut = 16;
  localparam int IdW = 16;
  localparam int TimeW = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_ADJUST = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_DUP = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  typedef struct packed {
    logic load;
    logic remove;
    logic insert;
    logic pop;
  } stq_cmd_t;

  typedef struct packed {
    logic found;
    logic full;
    logic next_due;
    logic head_due;
  } stq_stat_t;
endpackage

// ----- hw/rtl/stq_datapath.sv -----
// datapath: sorted chain of id and expiry registers with parallel compare
module stq_datapath import stq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  stq_cmd_t         cmd,
  input  logic [IdW-1:0]   in_id,
  input  logic [TimeW-1:0] in_exp,
  input  logic [TimeW-1:0] in_now,
  output stq_stat_t        stat,
  output logic [IdW-1:0]   head_id
);
  localparam int CW = $clog2(DEPTH + 1);

  logic [TimeW-1:0] exp_q [DEPTH];
  logic [IdW-1:0]   id_q  [DEPTH];
  logic [CW-1:0]    count;
  logic [IdW-1:0]   r_id;
  logic [TimeW-1:0] r_exp;
  logic [TimeW-1:0] r_now;
  logic [DEPTH-1:0] valid_v, hit_v, gt_v;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      valid_v[k] = CW'(k) < count;
      hit_v[k] = valid_v[k] && (id_q[k] == r_id);
      gt_v[k] = valid_v[k] && (exp_q[k] > r_exp);
    end
  end

  assign stat.found = |hit_v;
  assign stat.full = count == CW'(DEPTH);
  assign stat.next_due = (count > CW'(1)) && (exp_q[1] <= r_now);
  assign stat.head_due = (count != '0) && (exp_q[0] <= r_now);
  assign head_id = id_q[0];

  // remove shifts tail up over the hit (or head for pop); insert shifts down from first later
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_id <= in_id;
      r_exp <= in_exp;
      r_now <= in_now;
    end
    if (cmd.remove || cmd.pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        if (cmd.pop || (|(hit_v & ((DEPTH)'(1) << k | ((DEPTH)'(1) << k) - 1)))) begin
          exp_q[k] <= exp_q[k+1];
          id_q[k] <= id_q[k+1];
        end
      end
    end else if (cmd.insert) begin
      if (gt_v[0] || !valid_v[0]) begin
        exp_q[0] <= r_exp;
        id_q[0] <= r_id;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (gt_v[k-1]) begin
          exp_q[k] <= exp_q[k-1];
          id_q[k] <= id_q[k-1];
        end else if ((gt_v[k] || !valid_v[k]) && valid_v[k-1]) begin
          exp_q[k] <= r_exp;
          id_q[k] <= r_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.remove || cmd.pop) begin
      count <= count - CW'(1);
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end
  end
endmodule

// ----- hw/rtl/stq_ctrl.sv -----
// controller: sequences operations and drives the output register
module stq_ctrl import stq_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  input  logic [IdW-1:0] in_id,
  output logic           in_stall,
  output stq_cmd_t       cmd,
  input  stq_stat_t      stat,
  input  logic [IdW-1:0] head_id,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           result_kind,
  output logic [IdW-1:0] result_id,
  output logic [1:0]     status,
  output logic           last_of_run
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ADD2, S_TICK} state_t;
  localparam int NW = $clog2(MaxOut + 1);

  state_t state;
  logic [1:0] op;
  logic [IdW-1:0] id;
  logic [NW-1:0] npop;
  logic obuf_free;
  logic more;
  logic emit;

  assign obuf_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;
  assign more = stat.next_due && (npop < NW'(MaxOut - 1));
  assign emit = obuf_free && (state == S_EXEC || (state == S_TICK && stat.head_due));

  always_comb begin
    cmd = '0;
    cmd.load = state == S_IDLE && in_valid;
    unique case (state)
      S_EXEC: begin
        if (obuf_free && (op == OP_ADJUST || op == OP_DELETE)) cmd.remove = stat.found;
        if (obuf_free && op == OP_ADD) cmd.insert = !stat.found && !stat.full;
      end
      S_ADD2: cmd.insert = 1'b1;
      S_TICK: cmd.pop = obuf_free && stat.head_due;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= OP_ADD;
      npop <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= in_op;
          id <= in_id;
          npop <= '0;
          state <= in_op == OP_TICK ? S_TICK : S_EXEC;
        end
        S_EXEC: if (obuf_free) begin
          result_kind <= KIND_STATUS;
          result_id <= id;
          last_of_run <= 1'b1;
          if (op == OP_ADD) status <= stat.found ? ST_DUP : (stat.full ? ST_FULL : ST_OK);
          else status <= stat.found ? ST_OK : ST_UNKNOWN;
          state <= (op == OP_ADJUST && stat.found) ? S_ADD2 : S_IDLE;
        end
        S_ADD2: state <= S_IDLE;
        S_TICK: if (!stat.head_due) begin
          state <= S_IDLE;
        end else if (obuf_free) begin
          result_kind <= KIND_EXPIRED;
          result_id <= head_id;
          status <= ST_OK;
          npop <= npop + NW'(1);
          last_of_run <= !more;
          if (!more) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/sorted_timer_expiry_queue.sv -----
// top level of the sorted timer expiry queue
// Holds up to DEPTH timers (id, expiry) kept in ascending expiry order; equal
// expiries keep arrival order. Input beats carry operation, timer_id,
// expire_time and current_time under in_valid/in_stall; result beats carry
// result_kind, result_id, status and last_of_run under out_valid/out_stall.
// Add and delete capture the item, then do a parallel compare over the
// register chain and at most one shift; adjust removes, then inserts.
// A tick pops one due entry per cycle from the head of the chain while the
// output is not stalled, at most 16 per tick, marking the last with
// last_of_run; a tick with nothing due gives no beat. One item is worked on
// at a time. Results go through a single output register; while a result
// is held by out_stall the controller waits (an adjust's insertion still goes
// ahead). Reset empties the queue at once; entry contents are not cleared.
module sorted_timer_expiry_queue import stq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic [IdW-1:0]   timer_id,
  input  logic [TimeW-1:0] expire_time,
  input  logic [TimeW-1:0] current_time,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             result_kind,
  output logic [IdW-1:0]   result_id,
  output logic [1:0]       status,
  output logic             last_of_run
);
  stq_cmd_t cmd;
  stq_stat_t stat;
  logic [IdW-1:0] head_id;

  stq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .in_id(timer_id), .in_exp(expire_time), .in_now(current_time),
    .stat, .head_id
  );

  stq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_op(operation), .in_id(timer_id), .in_stall, .cmd, .stat,
    .head_id, .out_valid, .out_stall, .result_kind, .result_id, .status, .last_of_run
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.remove, cmd.insert, cmd.pop}) <= 1) else $error("commands overlap");
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> stat.head_due) else $error("pop without due entry");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full) else $error("insert into full chain");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_id)) else $error("result lost");
endmodule
